>>> hdl/crp_pkg.sv
// Shared types, constants and a width helper for the triangle cull and projection core.
// Depends on nothing; the core, front, cull and divider files import it.
`default_nettype none

package crp_pkg;

	// Default number of fraction bits of the fixed-point coordinates.
	localparam int FRAC_BITS_DEF = 16;

	// Register reset values (camera z is given in whole units).
	localparam int          CAM_Z_UNITS = -5;
	localparam logic [15:0] FOV_RST     = 16'd512;
	localparam logic [11:0] HALF_W_RST  = 12'd400;
	localparam logic [11:0] HALF_H_RST  = 12'd300;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_CAM_X  = 3'd0,
		REG_CAM_Y  = 3'd1,
		REG_CAM_Z  = 3'd2,
		REG_FOV    = 3'd3,
		REG_HALF_W = 3'd4,
		REG_HALF_H = 3'd5
	} reg_idx_t;

	// Configuration write word.
	typedef struct packed {
		reg_idx_t    reg_idx;
		logic [31:0] wdata;
	} cfg_t;

	// One input triangle.
	typedef struct packed {
		logic signed [31:0] v0_x;
		logic signed [31:0] v0_y;
		logic signed [31:0] v0_z;
		logic signed [31:0] v1_x;
		logic signed [31:0] v1_y;
		logic signed [31:0] v1_z;
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
	} tri_t;

	// One projected triangle.
	typedef struct packed {
		logic signed [31:0] p0_x;
		logic signed [31:0] p0_y;
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p2_x;
		logic signed [31:0] p2_y;
		logic               depth_zero;
	} pts_t;

	// Edge and ray vectors for the cull test.
	typedef struct packed {
		logic signed [32:0] bx;
		logic signed [32:0] by;
		logic signed [33:0] bz;
		logic signed [32:0] cx;
		logic signed [32:0] cy;
		logic signed [33:0] cz;
		logic signed [33:0] rx;
		logic signed [33:0] ry;
		logic signed [33:0] rz;
	} geom_t;

	// Numerators and shifted depths for the three vertices.
	typedef struct packed {
		logic [2:0][47:0] num_x;
		logic [2:0][47:0] num_y;
		logic [2:0][32:0] z;
	} proj_t;

	// Quotient width: wide enough that any quotient beyond it saturates the output.
	function automatic int quot_width(input int frac);
		return (frac + 13 > 32) ? frac + 13 : 32;
	endfunction

endpackage

`default_nettype wire

>>> hdl/crp_chan_if.sv
// Valid/ready channel carrying one payload word.
// Depends on nothing; the payload type is set per instance.
`default_nettype none

interface crp_chan_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/triangle_cull_and_project_core.sv
// Triangle back-face cull and perspective projection, fully pipelined.
// A triangle passes the front stages, then the restoring dividers, which retire one quotient
// bit per stage, then the output register. Throughput: one triangle per cycle unless the
// output stalls; culled triangles leave a bubble and give no word.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
`default_nettype none

module triangle_cull_and_project_core #(
	parameter int FRAC_BITS = crp_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	crp_chan_if.sink   tri_in,
	crp_chan_if.source pt_out,
	crp_chan_if.sink   cfg
);
	import crp_pkg::*;

	localparam int          QW        = quot_width(FRAC_BITS);
	localparam int          DIV_LAT   = QW + 1;
	localparam int          CULL_LAT  = 5;
	localparam logic [31:0] CAM_Z_RST = 32'(CAM_Z_UNITS * (2 ** FRAC_BITS));

	logic [31:0]   cam_x_q, cam_y_q, cam_z_q;
	logic [15:0]   fov_q;
	logic [11:0]   half_w_q, half_h_q;
	logic          en;
	logic          vld_s1, vld_s2;
	logic          pvld_s [DIV_LAT+1];
	logic          out_vld_q;
	pts_t          out_q;
	geom_t         geom;
	proj_t         proj;
	logic          keep;
	logic          ovf  [6];
	logic          neg  [6];
	logic          zero [6];
	logic [QW-1:0] quo  [6];

	// Saturating coordinate: signed quotient plus the screen offset, clamped to 32 bits.
	function automatic logic [31:0] place(input logic f_ovf, input logic f_neg,
		input logic [QW-1:0] f_quo, input logic [11:0] half);
		logic [QW:0]          mag;
		logic signed [QW+2:0] sv;
		logic signed [QW+2:0] sum;
		mag = f_ovf ? ((QW+1)'(1) << QW) : {1'b0, f_quo};
		sv  = f_neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
		sum = sv + $signed((QW+3)'(half) << FRAC_BITS);
		if (sum[QW+2:31] != {(QW-28){sum[31]}}) begin
			return sum[QW+2] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return sum[31:0];
	endfunction

	// The whole pipeline moves while the output register is free or being emptied.
	assign en           = !out_vld_q || pt_out.ready;
	assign tri_in.ready = en;
	assign cfg.ready    = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= CAM_Z_RST;
			fov_q    <= FOV_RST;
			half_w_q <= HALF_W_RST;
			half_h_q <= HALF_H_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.reg_idx)
				REG_CAM_X:  cam_x_q  <= cfg.data.wdata;
				REG_CAM_Y:  cam_y_q  <= cfg.data.wdata;
				REG_CAM_Z:  cam_z_q  <= cfg.data.wdata;
				REG_FOV:    fov_q    <= cfg.data.wdata[15:0];
				REG_HALF_W: half_w_q <= cfg.data.wdata[11:0];
				REG_HALF_H: half_h_q <= cfg.data.wdata[11:0];
				default: ;
			endcase
		end
	end

	crp_front u_front (
		.clk      (clk),
		.en       (en),
		.tri_word (tri_in.data),
		.cam_x    (cam_x_q),
		.cam_y    (cam_y_q),
		.cam_z    (cam_z_q),
		.fov      (fov_q),
		.geom     (geom),
		.proj     (proj)
	);

	crp_cull u_cull (
		.clk  (clk),
		.en   (en),
		.geom (geom),
		.keep (keep)
	);

	// One divider per output coordinate: even lanes x, odd lanes y.
	for (genvar k = 0; k < 3; k++) begin : g_vtx
		crp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
			.clk  (clk),
			.en   (en),
			.num  (proj.num_x[k]),
			.z    (proj.z[k]),
			.ovf  (ovf[2*k]),
			.neg  (neg[2*k]),
			.zero (zero[2*k]),
			.quo  (quo[2*k])
		);
		crp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
			.clk  (clk),
			.en   (en),
			.num  (proj.num_y[k]),
			.z    (proj.z[k]),
			.ovf  (ovf[2*k+1]),
			.neg  (neg[2*k+1]),
			.zero (zero[2*k+1]),
			.quo  (quo[2*k+1])
		);
	end

	// Valid bits follow the words; the cull verdict clears them once it is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i <= DIV_LAT; i++) begin
				pvld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1    <= tri_in.valid;
			vld_s2    <= vld_s1;
			pvld_s[0] <= vld_s2;
			for (int i = 1; i <= DIV_LAT; i++) begin
				pvld_s[i] <= (i == CULL_LAT) ? (pvld_s[i-1] && keep) : pvld_s[i-1];
			end
			out_vld_q <= pvld_s[DIV_LAT];
		end
	end

	// Output register: offsets, saturation and the zero-depth flag.
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.p0_x       <= place(ovf[0], neg[0], quo[0], half_w_q);
			out_q.p0_y       <= place(ovf[1], neg[1], quo[1], half_h_q);
			out_q.p1_x       <= place(ovf[2], neg[2], quo[2], half_w_q);
			out_q.p1_y       <= place(ovf[3], neg[3], quo[3], half_h_q);
			out_q.p2_x       <= place(ovf[4], neg[4], quo[4], half_w_q);
			out_q.p2_y       <= place(ovf[5], neg[5], quo[5], half_h_q);
			out_q.depth_zero <= zero[0] || zero[2] || zero[4];
		end
	end

	assign pt_out.valid = out_vld_q;
	assign pt_out.data  = out_q;

endmodule

`default_nettype wire

>>> hdl/crp_front.sv
// Front stages: camera shift of z, then edge, ray and projection numerators.
// Depends on crp_pkg.
`default_nettype none

module crp_front (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire crp_pkg::tri_t tri_word,
	input  wire logic [31:0]   cam_x,
	input  wire logic [31:0]   cam_y,
	input  wire logic [31:0]   cam_z,
	input  wire logic [15:0]   fov,
	output crp_pkg::geom_t     geom,
	output crp_pkg::proj_t     proj
);
	import crp_pkg::*;

	logic signed [31:0] x_s1 [3];
	logic signed [31:0] y_s1 [3];
	logic signed [32:0] z_s1 [3];
	geom_t              geom_s2;
	proj_t              proj_s2;
	logic signed [32:0] camz_ext;
	logic signed [16:0] fov_ext;

	assign camz_ext = $signed({cam_z[31], cam_z});
	assign fov_ext  = $signed({1'b0, fov});

	// Stage 1: register vertices with z moved into camera space.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1[0] <= tri_word.v0_x;
			x_s1[1] <= tri_word.v1_x;
			x_s1[2] <= tri_word.v2_x;
			y_s1[0] <= tri_word.v0_y;
			y_s1[1] <= tri_word.v1_y;
			y_s1[2] <= tri_word.v2_y;
			z_s1[0] <= $signed({tri_word.v0_z[31], tri_word.v0_z}) - camz_ext;
			z_s1[1] <= $signed({tri_word.v1_z[31], tri_word.v1_z}) - camz_ext;
			z_s1[2] <= $signed({tri_word.v2_z[31], tri_word.v2_z}) - camz_ext;
		end
	end

	// Stage 2: edges, ray from the first vertex, and scaled numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			geom_s2.bx <= 33'(x_s1[1]) - 33'(x_s1[0]);
			geom_s2.by <= 33'(y_s1[1]) - 33'(y_s1[0]);
			geom_s2.bz <= 34'(z_s1[1]) - 34'(z_s1[0]);
			geom_s2.cx <= 33'(x_s1[2]) - 33'(x_s1[0]);
			geom_s2.cy <= 33'(y_s1[2]) - 33'(y_s1[0]);
			geom_s2.cz <= 34'(z_s1[2]) - 34'(z_s1[0]);
			geom_s2.rx <= 34'($signed(cam_x)) - 34'(x_s1[0]);
			geom_s2.ry <= 34'($signed(cam_y)) - 34'(y_s1[0]);
			geom_s2.rz <= 34'(camz_ext) - 34'(z_s1[0]);
			for (int k = 0; k < 3; k++) begin
				proj_s2.num_x[k] <= 48'(fov_ext * x_s1[k]);
				proj_s2.num_y[k] <= 48'(fov_ext * y_s1[k]);
				proj_s2.z[k]     <= z_s1[k];
			end
		end
	end

	assign geom = geom_s2;
	assign proj = proj_s2;

endmodule

`default_nettype wire

>>> hdl/crp_cull.sv
// Back-face test: cross product of the edges dotted with the camera ray, five stages.
// Depends on crp_pkg.
`default_nettype none

module crp_cull (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire crp_pkg::geom_t geom,
	output logic                keep
);
	import crp_pkg::*;

	logic signed [66:0]  p_bycz_s1, p_bzcy_s1, p_bzcx_s1, p_bxcz_s1, p_bxcy_s1, p_bycx_s1;
	logic signed [33:0]  rx_s1, ry_s1, rz_s1;
	logic signed [67:0]  nx_s2, ny_s2, nz_s2;
	logic signed [33:0]  rx_s2, ry_s2, rz_s2;
	logic signed [67:0]  hx_s3, hy_s3, hz_s3;
	logic signed [68:0]  lx_s3, ly_s3, lz_s3;
	logic signed [103:0] tx_s4, ty_s4, tz_s4;
	logic signed [103:0] dot;
	logic                keep_s5;

	// Stage 1: the six cross-product terms.
	always_ff @(posedge clk) begin
		if (en) begin
			p_bycz_s1 <= 67'(geom.by * geom.cz);
			p_bzcy_s1 <= 67'(geom.bz * geom.cy);
			p_bzcx_s1 <= 67'(geom.bz * geom.cx);
			p_bxcz_s1 <= 67'(geom.bx * geom.cz);
			p_bxcy_s1 <= 67'(geom.bx * geom.cy);
			p_bycx_s1 <= 67'(geom.by * geom.cx);
			rx_s1     <= geom.rx;
			ry_s1     <= geom.ry;
			rz_s1     <= geom.rz;
		end
	end

	// Stage 2: normal components.
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= 68'(p_bycz_s1) - 68'(p_bzcy_s1);
			ny_s2 <= 68'(p_bzcx_s1) - 68'(p_bxcz_s1);
			nz_s2 <= 68'(p_bxcy_s1) - 68'(p_bycx_s1);
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			rz_s2 <= rz_s1;
		end
	end

	// Stage 3: each normal component times the ray, split into high and low halves.
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s3 <= 68'($signed(nx_s2[67:34]) * rx_s2);
			hy_s3 <= 68'($signed(ny_s2[67:34]) * ry_s2);
			hz_s3 <= 68'($signed(nz_s2[67:34]) * rz_s2);
			lx_s3 <= 69'($signed({1'b0, nx_s2[33:0]}) * rx_s2);
			ly_s3 <= 69'($signed({1'b0, ny_s2[33:0]}) * ry_s2);
			lz_s3 <= 69'($signed({1'b0, nz_s2[33:0]}) * rz_s2);
		end
	end

	// Stage 4: recombine the halves of each term.
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4 <= (104'(hx_s3) <<< 34) + 104'(lx_s3);
			ty_s4 <= (104'(hy_s3) <<< 34) + 104'(ly_s3);
			tz_s4 <= (104'(hz_s3) <<< 34) + 104'(lz_s3);
		end
	end

	// Stage 5: the triangle is kept unless the dot product is negative.
	assign dot = tx_s4 + ty_s4 + tz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			keep_s5 <= !dot[103];
		end
	end

	assign keep = keep_s5;

endmodule

`default_nettype wire

>>> hdl/crp_div.sv
// Pipelined restoring divider for one projected coordinate, one quotient bit per stage.
// Depends on crp_pkg for the quotient width.
`default_nettype none

module crp_div #(
	parameter int FRAC_BITS = crp_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [47:0] num,
	input  wire logic [32:0] z,
	output logic             ovf,
	output logic             neg,
	output logic             zero,
	output logic [crp_pkg::quot_width(FRAC_BITS)-1:0] quo
);
	import crp_pkg::*;

	localparam int QW = quot_width(FRAC_BITS);
	localparam int SH = QW - FRAC_BITS;

	logic [46:0]   mag_s1;
	logic [32:0]   den_s1;
	logic          neg_s1, zero_s1, nz_s1;
	logic [46:0]   hi;

	logic [32:0]   rem_s [QW+1];
	logic [32:0]   den_s [QW+1];
	logic [QW-1:0] dvd_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic          ovf_s [QW+1];
	logic          neg_s [QW+1];
	logic          zero_s [QW+1];

	// Stage 1: magnitudes and signs; a zero depth divides by one and is flagged.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= num[47] ? 47'(-$signed(num)) : num[46:0];
			den_s1  <= (z == '0) ? 33'd1 : (z[32] ? 33'(-$signed(z)) : z);
			neg_s1  <= num[47] ^ z[32];
			zero_s1 <= (z == '0);
			nz_s1   <= (num != '0);
		end
	end

	// Stage 2: overflow check on the high part, which also seeds the remainder.
	assign hi = mag_s1 >> SH;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi[32:0];
			den_s[0]  <= den_s1;
			dvd_s[0]  <= {mag_s1[SH-1:0], {FRAC_BITS{1'b0}}};
			quo_s[0]  <= '0;
			ovf_s[0]  <= zero_s1 ? nz_s1 : (hi >= {14'b0, den_s1});
			neg_s[0]  <= neg_s1;
			zero_s[0] <= zero_s1;
		end
	end

	// Iteration stages: shift in one dividend bit, subtract where it fits.
	for (genvar i = 1; i <= QW; i++) begin : g_iter
		logic [33:0] trial;
		logic        fits;

		assign trial = {rem_s[i-1], dvd_s[i-1][QW-1]};
		assign fits  = (trial >= {1'b0, den_s[i-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fits ? 33'(trial - {1'b0, den_s[i-1]}) : trial[32:0];
				den_s[i]  <= den_s[i-1];
				dvd_s[i]  <= dvd_s[i-1] << 1;
				quo_s[i]  <= {quo_s[i-1][QW-2:0], fits};
				ovf_s[i]  <= ovf_s[i-1];
				neg_s[i]  <= neg_s[i-1];
				zero_s[i] <= zero_s[i-1];
			end
		end
	end

	assign ovf  = ovf_s[QW];
	assign neg  = neg_s[QW];
	assign zero = zero_s[QW];
	assign quo  = quo_s[QW];

endmodule

`default_nettype wire
